// File: hw/rtl/mtsc_pkg.sv
package mtsc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W = 10;
  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
  localparam logic [15:0] PRIME_RESET = 16'd9999;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PRIME = 2'd1,
    CMD_CRYPT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        idx_ok;
    logic [9:0]  seed_index;
    logic [31:0] seed_word;
    logic [7:0]  byte_in;
  } job_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

// File: hw/rtl/mt_multiplicative_stream_cipher.sv
// Load writes one state word; encrypt draws one word and twists the state every 624 words.
// Prime draws one word per round from the state RAM, with twists as needed.
// The back end handles one word at a time.
// A two-entry queue lets input words be taken while the back end works.
// Reset: accumulator 1, generator position 624, round count 9999, queue empty, no output pending.
// State RAM is not cleared; words must be loaded before use.
module mt_multiplicative_stream_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // cmd[1:0], seed_index[11:2], seed_word[43:12], byte_in[51:44]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // byte_out[7:0], command_done[8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]    rounds_r;
  logic           q_valid, q_pop, busy;
  mtsc_pkg::job_t q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rounds_r <= mtsc_pkg::PRIME_RESET;
    end else if (cfg_valid) begin
      rounds_r <= cfg_data;
    end
  end

  mtsc_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_cmd(in_tdata[1:0]), .in_seed_index(in_tdata[11:2]),
    .in_seed_word(in_tdata[43:12]), .in_byte_in(in_tdata[51:44]),
    .q_valid, .q_pop, .q_job
  );

  mtsc_back u_back (
    .clk, .rst_n, .rounds(rounds_r), .q_valid, .q_pop, .q_job,
    .out_tvalid, .out_tready, .out_tdata, .busy
  );

  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:9] == 7'd0) else $error("out pad");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop empty");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> out_tdata[7:0] == 8'd0) else $error("byte w/o done");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> busy) else $error("out while idle");

endmodule

// File: hw/rtl/mtsc_front.sv
module mtsc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_cmd,
  input  logic [9:0]     in_seed_index,
  input  logic [31:0]    in_seed_word,
  input  logic [7:0]     in_byte_in,
  output logic           q_valid,
  input  logic           q_pop,
  output mtsc_pkg::job_t q_job
);

  mtsc_pkg::job_t slot_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           push;
  mtsc_pkg::job_t job;

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign q_job     = slot_r[rp_r];

  always_comb begin
    job.cmd        = mtsc_pkg::cmd_t'(in_cmd);
    job.idx_ok     = (in_seed_index < 10'(mtsc_pkg::STATE_WORDS));
    job.seed_index = in_seed_index;
    job.seed_word  = in_seed_word;
    job.byte_in    = in_byte_in;
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= job;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/mtsc_back.sv
module mtsc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [15:0]    rounds,
  input  logic           q_valid,
  output logic           q_pop,
  input  mtsc_pkg::job_t q_job,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,
  output logic           busy
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DISP  = 9'b000000010,
    S_TW0   = 9'b000000100,
    S_TW1   = 9'b000001000,
    S_TW2   = 9'b000010000,
    S_TW3   = 9'b000100000,
    S_GEN   = 9'b001000000,
    S_MUL   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t         st_r, st_nxt;
  logic [31:0]    mem [mtsc_pkg::STATE_WORDS];
  logic [31:0]    rd_r;
  logic [9:0]     pos_r, ti_r, ra;
  logic [31:0]    acc_r, a_r, b_r, mul_r;
  logic [15:0]    left_r;
  logic           mode_r;
  logic [7:0]     bout_r;
  logic [15:0]    obuf_r;
  logic           ovld_r;
  logic [9:0]     n1, nf;
  logic [31:0]    y, v;
  mtsc_pkg::job_t job_r;

  assign n1 = (ti_r == 10'(mtsc_pkg::STATE_WORDS - 1)) ? 10'd0 : ti_r + 10'd1;
  assign nf = (ti_r >= 10'(mtsc_pkg::STATE_WORDS - mtsc_pkg::TWIST_OFFSET)) ?
              ti_r - 10'(mtsc_pkg::STATE_WORDS - mtsc_pkg::TWIST_OFFSET) :
              ti_r + 10'(mtsc_pkg::TWIST_OFFSET);
  assign y = {a_r[31], b_r[30:0]};
  assign v = rd_r ^ (y >> 1) ^ (y[0] ? mtsc_pkg::TWIST_MATRIX : 32'd0);

  assign q_pop      = (st_r == S_IDLE) && q_valid;
  assign out_tvalid = ovld_r;
  assign out_tdata  = obuf_r;
  assign busy       = (st_r != S_IDLE) || ovld_r;

  always_comb begin
    case (st_r)
      S_TW0:   ra = ti_r;
      S_TW1:   ra = n1;
      S_TW2:   ra = nf;
      S_TW3:   ra = n1;
      default: ra = pos_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
    if (st_r == S_DISP && job_r.cmd == mtsc_pkg::CMD_LOAD && job_r.idx_ok) begin
      mem[job_r.seed_index] <= job_r.seed_word;
    end else if (st_r == S_TW3) begin
      mem[ti_r] <= v;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_DISP;
      S_DISP: begin
        case (job_r.cmd)
          mtsc_pkg::CMD_LOAD:  st_nxt = S_OUT;
          mtsc_pkg::CMD_PRIME: st_nxt = (rounds == 16'd0) ? S_OUT :
                                 (pos_r >= 10'(mtsc_pkg::STATE_WORDS)) ? S_TW0 : S_GEN;
          mtsc_pkg::CMD_CRYPT: st_nxt = (pos_r >= 10'(mtsc_pkg::STATE_WORDS)) ? S_TW0 : S_GEN;
          default:             st_nxt = S_OUT;
        endcase
      end
      S_TW0: st_nxt = S_TW1;
      S_TW1: st_nxt = S_TW2;
      S_TW2: st_nxt = S_TW3;
      S_TW3: st_nxt = (ti_r == 10'(mtsc_pkg::STATE_WORDS - 1)) ? S_GEN : S_TW0;
      S_GEN: st_nxt = S_MUL;
      S_MUL: st_nxt = S_IDLE;
      S_OUT: if (!ovld_r || out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_MUL) begin
      if (left_r > 16'd1) begin
        st_nxt = (pos_r >= 10'(mtsc_pkg::STATE_WORDS)) ? S_TW0 : S_GEN;
      end else begin
        st_nxt = S_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
    case (st_r)
      S_DISP: begin
        left_r <= (job_r.cmd == mtsc_pkg::CMD_PRIME) ? rounds : 16'd1;
        mode_r <= (job_r.cmd == mtsc_pkg::CMD_CRYPT);
        bout_r <= (job_r.cmd == mtsc_pkg::CMD_CRYPT) ? (acc_r[31:24] ^ job_r.byte_in) : 8'd0;
        ti_r   <= 10'd0;
      end
      S_TW1: a_r <= rd_r;
      S_TW2: b_r <= rd_r;
      S_GEN: mul_r <= mtsc_pkg::temper(rd_r) | 32'd1;
      S_MUL: left_r <= left_r - 16'd1;
      default: ;
    endcase
    if (st_r == S_TW3) ti_r <= n1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      pos_r  <= 10'(mtsc_pkg::STATE_WORDS);
      acc_r  <= 32'd1;
      ovld_r <= 1'b0;
      obuf_r <= 16'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DISP && job_r.cmd == mtsc_pkg::CMD_LOAD && job_r.idx_ok)
        pos_r <= 10'(mtsc_pkg::STATE_WORDS);
      if (st_r == S_DISP && job_r.cmd == mtsc_pkg::CMD_PRIME) acc_r <= 32'd1;
      if (st_r == S_TW3 && ti_r == 10'(mtsc_pkg::STATE_WORDS - 1)) pos_r <= 10'd0;
      if (st_r == S_GEN) pos_r <= pos_r + 10'd1;
      if (st_r == S_MUL) acc_r <= acc_r * mul_r;
      if (st_r == S_OUT && (!ovld_r || out_tready)) begin
        ovld_r <= 1'b1;
        obuf_r <= {7'd0, job_r.cmd != mtsc_pkg::CMD_NONE,
                   mode_r && job_r.cmd == mtsc_pkg::CMD_CRYPT ? bout_r : 8'd0};
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

endmodule

// File: sim/mtsc_checker.sv
module mtsc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] byte_out;
    logic       done;
  } cipher_result_t;

  logic [31:0]    gen_words [mtsc_pkg::STATE_WORDS];
  int unsigned    gen_pos;
  logic [31:0]    acc;
  logic [15:0]    rounds;
  cipher_result_t expected_bytes [$];

  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] v;
    for (int i = 0; i < mtsc_pkg::STATE_WORDS; i++) begin
      y = (gen_words[i] & 32'h8000_0000) |
          (gen_words[(i + 1) % mtsc_pkg::STATE_WORDS] & 32'h7FFF_FFFF);
      v = gen_words[(i + mtsc_pkg::TWIST_OFFSET) % mtsc_pkg::STATE_WORDS] ^ (y >> 1);
      if (y[0]) v = v ^ mtsc_pkg::TWIST_MATRIX;
      gen_words[i] = v;
    end
    gen_pos = 0;
  endfunction

  function automatic logic [31:0] draw_word();
    logic [31:0] y;
    if (gen_pos >= mtsc_pkg::STATE_WORDS) twist_state();
    y = gen_words[gen_pos];
    gen_pos++;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & 32'h9D2C5680);
    y = y ^ ((y << 15) & 32'hEFC60000);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic cipher_result_t predict_byte(logic [55:0] d);
    cipher_result_t r;
    mtsc_pkg::cmd_t c;
    logic [9:0]     idx;
    c = mtsc_pkg::cmd_t'(d[1:0]);
    idx = d[11:2];
    r.byte_out = '0;
    r.done = 1'b0;
    case (c)
      mtsc_pkg::CMD_LOAD: begin
        if (idx < mtsc_pkg::STATE_WORDS) begin
          gen_words[idx] = d[43:12];
          gen_pos = mtsc_pkg::STATE_WORDS;
        end
        r.done = 1'b1;
      end
      mtsc_pkg::CMD_PRIME: begin
        acc = 32'd1;
        for (int k = 0; k < rounds; k++) acc = acc * (draw_word() | 32'd1);
        r.done = 1'b1;
      end
      mtsc_pkg::CMD_CRYPT: begin
        r.byte_out = acc[31:24] ^ d[51:44];
        acc = acc * (draw_word() | 32'd1);
        r.done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    cipher_result_t want;
    if (!rst_n) begin
      foreach (gen_words[i]) gen_words[i] = '0;
      gen_pos = mtsc_pkg::STATE_WORDS;
      acc = 32'd1;
      rounds = mtsc_pkg::PRIME_RESET;
      expected_bytes.delete();
      fails = 0;
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) rounds = cfg_data;
      if (in_tvalid && in_tready) expected_bytes.push_back(predict_byte(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected word: tdata=%h", out_tdata);
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata[7:0] !== want.byte_out || out_tdata[8] !== want.done) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: byte_out exp %h got %h, done exp %b got %b",
                       want.byte_out, out_tdata[7:0], want.done, out_tdata[8]);
          end
        end
      end
      pending = expected_bytes.size();
    end
  end
endmodule

// File: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4_000_000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  int          fails;
  int          pending;
  int          idle_pct;
  bit          hold_req;
  bit          hold_done;
  longint      cycles = 0;
  int          sent;

  mt_multiplicative_stream_cipher DUT (.*);

  mtsc_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      out_tready <= 1'b0;
      repeat (400) @(negedge clk);
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task automatic send_word(mtsc_pkg::cmd_t c, logic [9:0] idx, logic [31:0] w,
                           logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, b, w, idx, c};
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_rounds(logic [15:0] n);
    cfg_valid <= 1'b1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic crypt_byte();
    send_word(mtsc_pkg::CMD_CRYPT, 10'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic load_word();
    send_word(mtsc_pkg::CMD_LOAD, 10'($urandom_range(mtsc_pkg::STATE_WORDS - 1)), $urandom,
              8'($urandom));
  endtask

  task automatic odd_word();
    case ($urandom_range(2))
      0: send_word(mtsc_pkg::CMD_NONE, 10'($urandom), $urandom, 8'($urandom));
      1: send_word(mtsc_pkg::CMD_LOAD, 10'($urandom_range(1023, mtsc_pkg::STATE_WORDS)),
                   $urandom, 8'($urandom));
      default: load_word();
    endcase
  endtask

  initial begin
    int n;
    int r;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    idle_pct = 6;
    hold_req = 1'b0;
    sent = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < mtsc_pkg::STATE_WORDS; i++)
      send_word(mtsc_pkg::CMD_LOAD, 10'(i), $urandom, 8'($urandom));
    send_word(mtsc_pkg::CMD_NONE, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
    send_word(mtsc_pkg::CMD_LOAD, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
    send_word(mtsc_pkg::CMD_LOAD, 10'(mtsc_pkg::STATE_WORDS), 32'h1234_5678, 8'h00);
    send_word(mtsc_pkg::CMD_LOAD, 10'd0, 32'hFFFF_FFFF, 8'h00);
    send_word(mtsc_pkg::CMD_LOAD, 10'(mtsc_pkg::STATE_WORDS - 1), 32'h0, 8'h00);
    send_word(mtsc_pkg::CMD_CRYPT, 10'd0, 32'h0, 8'h00);
    send_word(mtsc_pkg::CMD_CRYPT, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
    send_word(mtsc_pkg::CMD_PRIME, 10'd0, 32'h0, 8'h00);
    repeat (4) crypt_byte();
    drain();
    write_rounds(16'd0);
    send_word(mtsc_pkg::CMD_PRIME, 10'd0, 32'h0, 8'h00);
    send_word(mtsc_pkg::CMD_CRYPT, 10'd0, 32'h0, 8'hFF);
    drain();
    write_rounds(16'hFFFF);
    send_word(mtsc_pkg::CMD_PRIME, 10'h3FF, 32'hFFFF_FFFF, 8'hFF);
    send_word(mtsc_pkg::CMD_CRYPT, 10'd0, 32'h0, 8'h5A);
    drain();
    write_rounds(16'd1);
    send_word(mtsc_pkg::CMD_PRIME, 10'd0, 32'h0, 8'h00);
    send_word(mtsc_pkg::CMD_CRYPT, 10'd0, 32'h0, 8'hA5);

    for (int ph = 0; ph < 25; ph++) begin
      drain();
      idle_pct = (ph >= 6 && ph < 11) ? 0 : 6;
      r = ($urandom_range(9) == 0) ? 0 : $urandom_range(24, 1);
      write_rounds(16'(r));
      if ($urandom_range(9) == 0) begin
        n = $urandom_range(4, 1);
        repeat (n) load_word();
      end
      send_word(mtsc_pkg::CMD_PRIME, 10'($urandom), $urandom, 8'($urandom));
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < 28; k++) begin
        if ($urandom_range(99) < 6) odd_word();
        else crypt_byte();
      end
    end

    drain();
    repeat (50) @(negedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
